@@ rtl/core/triangle_transform_measure_defines.svh @@
// Assertion macros for the triangle transform and measure block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef TRIANGLE_TRANSFORM_MEASURE_DEFINES_SVH
`define TRIANGLE_TRANSFORM_MEASURE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ttm_pkg.sv @@
// Shared types, constants and helper functions of the triangle block.
// No dependencies; imported by every module of the block.
package ttm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_GUARD    = 8;
  localparam int VTX_COUNT    = 3;
  localparam int ROOT_BITS    = 33;

  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 280;
  localparam int OUT_USER_W = 2;

  // CORDIC gain 0.60725293500888 with 32 fraction bits
  localparam logic [32:0] GAIN_Q32 = 33'd2608131496;

  // Angles in degrees with 24 fraction bits
  localparam logic signed [35:0] ANG_90  = 36'sd1509949440;
  localparam logic signed [35:0] ANG_180 = 36'sd3019898880;
  localparam logic signed [35:0] ANG_360 = 36'sd6039797760;

  localparam logic signed [44:0] COORD_MAX = 45'sd2147483647;
  localparam logic signed [44:0] COORD_MIN = -45'sd2147483648;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [32:0]               mul_op_t;
  typedef logic [65:0]               prod_t;
  typedef logic signed [43:0]        cord_t;

  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_TRANSLATE = 3'd1,
    ACT_ROTATE    = 3'd2,
    ACT_ZOOM      = 3'd3,
    ACT_QUERY     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_EQUI     = 2'd0,
    KIND_RIGHT    = 2'd1,
    KIND_ISO      = 2'd2,
    KIND_SCALENE  = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_APPLY, ST_ZOOM_MUL, ST_ZOOM_WB, ST_ROT_PREP, ST_GAIN_X,
    ST_GAIN_Y, ST_GAIN_WB, ST_CORDIC, ST_ROT_WB, ST_SIDE_DX, ST_SIDE_DY,
    ST_SIDE_SUM, ST_SQRT, ST_CROSS_A, ST_CROSS_B, ST_CROSS_C, ST_KIND,
    ST_DONE
  } state_e;

  // Saturate a wide signed value to a coordinate
  function automatic coord_t sat_coord(input logic signed [44:0] v);
    if (v > COORD_MAX) begin
      return COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      return COORD_MIN[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  // Magnitude of a 33-bit signed value, as unsigned
  function automatic mul_op_t mag33(input logic signed [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  // Arctangent of 2^-i in degrees, 24 fraction bits
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [30:0] tail;
    tail = (31'd961263669 + (31'd1 << (i - 5'd1))) >> i;
    case (i)
      5'd0:    return 30'd754974720;
      5'd1:    return 30'd445687602;
      5'd2:    return 30'd235489088;
      5'd3:    return 30'd119537938;
      5'd4:    return 30'd60000934;
      5'd5:    return 30'd30029717;
      5'd6:    return 30'd15018523;
      5'd7:    return 30'd7509720;
      5'd8:    return 30'd3754917;
      5'd9:    return 30'd1877466;
      5'd10:   return 30'd938734;
      5'd11:   return 30'd469367;
      default: return tail[29:0];
    endcase
  endfunction

endpackage

@@ rtl/core/ttm_mult.sv @@
// Shared unsigned 33x33 multiplier with a registered product.
// Depends on ttm_pkg for operand and product types.
module ttm_mult (
  input  logic             clk_i,
  input  ttm_pkg::mul_op_t a_i,
  input  ttm_pkg::mul_op_t b_i,
  output ttm_pkg::prod_t   prod_o
);
  import ttm_pkg::*;

  prod_t prod_q;

  // one product per cycle, available the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= {33'd0, a_i} * {33'd0, b_i};
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/core/ttm_sqrt.sv @@
// Digit-recurrence square root, one result bit per cycle, rounded to nearest.
// Depends on ttm_pkg for the product type and root width.
module ttm_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  ttm_pkg::prod_t           radicand_i,
  output logic                     done_o,
  output logic [ttm_pkg::ROOT_BITS:0] root_o
);
  import ttm_pkg::*;

  prod_t                rad_q;
  logic [35:0]          rem_q, rem_d, rem_sh, trial;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [5:0]           cnt_q;
  logic                 busy_q, done_q;

  // one recurrence step
  always_comb begin
    rem_sh = {rem_q[33:0], rad_q[65:64]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_BITS-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(ROOT_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[63:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // round up when the remainder exceeds the root
  assign root_o = {1'b0, root_q} + {{ROOT_BITS{1'b0}}, (rem_q > {3'b000, root_q})};
  assign done_o = done_q;

endmodule

@@ rtl/core/triangle_transform_measure.sv @@
// One item at a time: the input is not ready again until the result of the
// last item has been posted. The three 33-step square roots of the sides
// are common to every action; rotate adds 24 CORDIC steps per vertex.
// Reset (asynchronous, active low) clears the vertices, the FSM and sets the
// equality tolerance to 4.
module triangle_transform_measure (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // value_x[31:0], value_y[63:32], angle_deg[89:64], zoom_factor[121:90]
  input  logic [ttm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // action[2:0], vertex_index[4:3]
  input  logic [ttm_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // ax, ay, bx, by_coord, cx, cy (32 each), perimeter[225:192], area[273:226]
  output logic [ttm_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // kind[1:0]
  output logic [ttm_pkg::OUT_USER_W-1:0]   m_axis_tuser_o,
  input  logic                             cfg_we_i,
  input  logic [31:0]                      cfg_wdata_i
);
  import ttm_pkg::*;

  state_e state_q, state_d;

  // latched request
  logic [2:0]         act_q;
  logic [1:0]         vsel_q;
  coord_t             inx_q, iny_q, zf_q;
  logic signed [25:0] ang_q;
  logic [31:0]        tol_q;

  coord_t vx_q [VTX_COUNT];
  coord_t vy_q [VTX_COUNT];

  // sequencer counters
  logic [1:0] vidx_q;
  logic [2:0] coord_q;
  logic [4:0] iter_q;
  logic [2:0] kcnt_q;

  // rotation and measurement registers
  cord_t              cx_q, cy_q;
  logic signed [33:0] cz_q, z0_q;
  logic               flip_q;
  prod_t              acc_q;
  prod_t              sq_q [VTX_COUNT];
  logic [35:0]        per_q;
  logic signed [67:0] p1_q, cross_q;
  logic [5:0]         flags_q;

  // output register
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]            out_kind_q;
  logic                  m_valid_q;

  // shared units
  mul_op_t           mul_a, mul_b;
  prod_t             prod;
  logic              sq_start, sq_done;
  logic [ROOT_BITS:0] sq_root;

  ttm_mult u_mult (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ttm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (acc_q + prod),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  logic s_fire, out_free;
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // operand selection
  coord_t             zc, cur_x, cur_y;
  logic signed [32:0] sdx, sdy, d1x, d1y, d2x, d2y;

  assign zc    = coord_q[0] ? vy_q[coord_q[2:1]] : vx_q[coord_q[2:1]];
  assign cur_x = vx_q[vidx_q];
  assign cur_y = vy_q[vidx_q];

  always_comb begin
    case (vidx_q)
      2'd0: begin
        sdx = {vx_q[0][31], vx_q[0]} - {vx_q[1][31], vx_q[1]};
        sdy = {vy_q[0][31], vy_q[0]} - {vy_q[1][31], vy_q[1]};
      end
      2'd1: begin
        sdx = {vx_q[1][31], vx_q[1]} - {vx_q[2][31], vx_q[2]};
        sdy = {vy_q[1][31], vy_q[1]} - {vy_q[2][31], vy_q[2]};
      end
      default: begin
        sdx = {vx_q[2][31], vx_q[2]} - {vx_q[0][31], vx_q[0]};
        sdy = {vy_q[2][31], vy_q[2]} - {vy_q[0][31], vy_q[0]};
      end
    endcase
  end

  assign d1x = {vx_q[1][31], vx_q[1]} - {vx_q[0][31], vx_q[0]};
  assign d1y = {vy_q[1][31], vy_q[1]} - {vy_q[0][31], vy_q[0]};
  assign d2x = {vx_q[2][31], vx_q[2]} - {vx_q[0][31], vx_q[0]};
  assign d2y = {vy_q[2][31], vy_q[2]} - {vy_q[0][31], vy_q[0]};

  // zoom write-back: round half away from zero, saturate
  logic        z_neg;
  prod_t       z_full, z_lim;
  logic [31:0] z_mag;
  coord_t      z_res;

  always_comb begin
    z_neg  = zc[31] ^ zf_q[31];
    z_full = (prod + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    z_lim  = 66'd2147483647 + {65'd0, z_neg};
    z_mag  = (z_full > z_lim) ? z_lim[31:0] : z_full[31:0];
    z_res  = z_neg ? (~z_mag + 32'd1) : z_mag;
  end

  // gain scaling into guard bits
  prod_t g_full;
  cord_t g_mag;
  logic  g_neg_x, g_neg_y;

  assign g_full  = (prod + (66'd1 << (31 - ANG_GUARD))) >> (32 - ANG_GUARD);
  assign g_mag   = {2'b00, g_full[41:0]};
  assign g_neg_x = cur_x[31] ^ flip_q;
  assign g_neg_y = cur_y[31] ^ flip_q;

  // angle folding
  logic signed [35:0] fa0, fa1, fa2, fz;
  logic               ffl;

  always_comb begin
    fa0 = {{2{ang_q[25]}}, ang_q, 8'd0};
    if (fa0 > ANG_180)       fa1 = fa0 - ANG_360;
    else if (fa0 < -ANG_180) fa1 = fa0 + ANG_360;
    else                     fa1 = fa0;
    if (fa1 > ANG_180)       fa2 = fa1 - ANG_360;
    else if (fa1 < -ANG_180) fa2 = fa1 + ANG_360;
    else                     fa2 = fa1;
    ffl = 1'b1;
    if (fa2 > ANG_90)        fz = fa2 - ANG_180;
    else if (fa2 < -ANG_90)  fz = fa2 + ANG_180;
    else begin
      fz  = fa2;
      ffl = 1'b0;
    end
  end

  // CORDIC micro-rotation through variable arithmetic shifts
  cord_t              xs, ys;
  logic signed [33:0] at;
  coord_t             rx, ry;

  assign xs = cx_q >>> iter_q;
  assign ys = cy_q >>> iter_q;
  assign at = $signed({4'd0, atan_entry(iter_q)});
  assign rx = sat_coord(($signed({cx_q[43], cx_q}) + 45'sd128) >>> ANG_GUARD);
  assign ry = sat_coord(($signed({cy_q[43], cy_q}) + 45'sd128) >>> ANG_GUARD);

  // shared tolerance compare for the kind tests
  logic [67:0] kp, kq, kdiff;
  logic        khit;

  always_comb begin
    case (kcnt_q)
      3'd0: begin kp = {2'b0, sq_q[0]}; kq = {2'b0, sq_q[1]}; end
      3'd1: begin kp = {2'b0, sq_q[1]}; kq = {2'b0, sq_q[2]}; end
      3'd2: begin kp = {2'b0, sq_q[2]}; kq = {2'b0, sq_q[0]}; end
      3'd3: begin kp = {2'b0, sq_q[0]} + {2'b0, sq_q[1]}; kq = {2'b0, sq_q[2]}; end
      3'd4: begin kp = {2'b0, sq_q[1]} + {2'b0, sq_q[2]}; kq = {2'b0, sq_q[0]}; end
      default: begin kp = {2'b0, sq_q[2]} + {2'b0, sq_q[0]}; kq = {2'b0, sq_q[1]}; end
    endcase
    kdiff = (kp >= kq) ? (kp - kq) : (kq - kp);
    khit  = kdiff <= {36'd0, tol_q};
  end

  // result assembly
  logic [67:0] acr, at_full;
  logic [47:0] area;
  logic [33:0] perim;
  kind_e       kind;

  always_comb begin
    acr     = cross_q[67] ? (~cross_q + 68'd1) : cross_q;
    at_full = (acr + (68'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
    area    = (|at_full[67:48]) ? '1 : at_full[47:0];
    perim   = (|per_q[35:34]) ? '1 : per_q[33:0];
    if (flags_q[0] && flags_q[1])                    kind = KIND_EQUI;
    else if (flags_q[3] || flags_q[4] || flags_q[5]) kind = KIND_RIGHT;
    else if (flags_q[0] || flags_q[1] || flags_q[2]) kind = KIND_ISO;
    else                                             kind = KIND_SCALENE;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (s_axis_tvalid_i) state_d = ST_APPLY;
      ST_APPLY: begin
        case (act_q)
          ACT_ROTATE: state_d = ST_ROT_PREP;
          ACT_ZOOM:   state_d = ST_ZOOM_MUL;
          default:    state_d = ST_SIDE_DX;
        endcase
      end
      ST_ZOOM_MUL: state_d = ST_ZOOM_WB;
      ST_ZOOM_WB:  state_d = (coord_q == 3'd5) ? ST_SIDE_DX : ST_ZOOM_MUL;
      ST_ROT_PREP: state_d = ST_GAIN_X;
      ST_GAIN_X:   state_d = ST_GAIN_Y;
      ST_GAIN_Y:   state_d = ST_GAIN_WB;
      ST_GAIN_WB:  state_d = ST_CORDIC;
      ST_CORDIC:   if (iter_q == 5'(CORDIC_STEPS - 1)) state_d = ST_ROT_WB;
      ST_ROT_WB:   state_d = (vidx_q == 2'd2) ? ST_SIDE_DX : ST_GAIN_X;
      ST_SIDE_DX:  state_d = ST_SIDE_DY;
      ST_SIDE_DY:  state_d = ST_SIDE_SUM;
      ST_SIDE_SUM: state_d = ST_SQRT;
      ST_SQRT:     if (sq_done) state_d = (vidx_q == 2'd2) ? ST_CROSS_A : ST_SIDE_DX;
      ST_CROSS_A:  state_d = ST_CROSS_B;
      ST_CROSS_B:  state_d = ST_CROSS_C;
      ST_CROSS_C:  state_d = ST_KIND;
      ST_KIND:     if (kcnt_q == 3'd5) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    unique case (state_q)
      ST_ZOOM_MUL: begin
        mul_a = mag33({zc[31], zc});
        mul_b = mag33({zf_q[31], zf_q});
      end
      ST_GAIN_X: begin
        mul_a = mag33({cur_x[31], cur_x});
        mul_b = GAIN_Q32;
      end
      ST_GAIN_Y: begin
        mul_a = mag33({cur_y[31], cur_y});
        mul_b = GAIN_Q32;
      end
      ST_SIDE_DX: begin
        mul_a = mag33(sdx);
        mul_b = mag33(sdx);
      end
      ST_SIDE_DY: begin
        mul_a = mag33(sdy);
        mul_b = mag33(sdy);
      end
      ST_SIDE_SUM: sq_start = 1'b1;
      ST_CROSS_A: begin
        mul_a = mag33(d1x);
        mul_b = mag33(d2y);
      end
      ST_CROSS_B: begin
        mul_a = mag33(d1y);
        mul_b = mag33(d2x);
      end
      default: ;
    endcase
  end

  // control state and vertices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tol_q     <= 32'd4;
      m_valid_q <= 1'b0;
      vidx_q    <= '0;
      coord_q   <= '0;
      iter_q    <= '0;
      kcnt_q    <= '0;
      for (int k = 0; k < VTX_COUNT; k++) begin
        vx_q[k] <= '0;
        vy_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      // post a new result or retire the one taken
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_APPLY: begin
          vidx_q  <= '0;
          coord_q <= '0;
          if (act_q == ACT_LOAD && vsel_q < 2'(VTX_COUNT)) begin
            vx_q[vsel_q] <= inx_q;
            vy_q[vsel_q] <= iny_q;
          end else if (act_q == ACT_TRANSLATE) begin
            for (int k = 0; k < VTX_COUNT; k++) begin
              vx_q[k] <= sat_coord(45'(vx_q[k]) + 45'(inx_q));
              vy_q[k] <= sat_coord(45'(vy_q[k]) + 45'(iny_q));
            end
          end
        end
        ST_ZOOM_WB: begin
          if (coord_q[0]) vy_q[coord_q[2:1]] <= z_res;
          else            vx_q[coord_q[2:1]] <= z_res;
          coord_q <= coord_q + 3'd1;
        end
        ST_GAIN_WB: iter_q <= '0;
        ST_CORDIC:  iter_q <= iter_q + 5'd1;
        ST_ROT_WB: begin
          vx_q[vidx_q] <= rx;
          vy_q[vidx_q] <= ry;
          vidx_q <= (vidx_q == 2'd2) ? 2'd0 : vidx_q + 2'd1;
        end
        ST_SQRT:    if (sq_done) vidx_q <= (vidx_q == 2'd2) ? 2'd0 : vidx_q + 2'd1;
        ST_CROSS_C: kcnt_q <= '0;
        ST_KIND:    kcnt_q <= kcnt_q + 3'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      inx_q  <= s_axis_tdata_i[31:0];
      iny_q  <= s_axis_tdata_i[63:32];
      ang_q  <= s_axis_tdata_i[89:64];
      zf_q   <= s_axis_tdata_i[121:90];
      act_q  <= s_axis_tuser_i[2:0];
      vsel_q <= s_axis_tuser_i[4:3];
    end
    unique case (state_q)
      ST_APPLY: per_q <= '0;
      ST_ROT_PREP: begin
        z0_q   <= fz[33:0];
        flip_q <= ffl;
      end
      ST_GAIN_Y:  cx_q <= g_neg_x ? (~g_mag + 44'sd1) : g_mag;
      ST_GAIN_WB: begin
        cy_q <= g_neg_y ? (~g_mag + 44'sd1) : g_mag;
        cz_q <= z0_q;
      end
      ST_CORDIC: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
      end
      ST_SIDE_DY:  acc_q <= prod;
      ST_SIDE_SUM: sq_q[vidx_q] <= acc_q + prod;
      ST_SQRT:     if (sq_done) per_q <= per_q + {2'b00, sq_root};
      ST_CROSS_B: begin
        p1_q <= (d1x[32] ^ d2y[32]) ? (~{2'b00, prod} + 68'sd1) : {2'b00, prod};
      end
      ST_CROSS_C: begin
        cross_q <= p1_q - ((d1y[32] ^ d2x[32]) ? (~{2'b00, prod} + 68'sd1)
                                               : {2'b00, prod});
      end
      ST_KIND:    flags_q[kcnt_q] <= khit;
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= {6'd0, area, perim, vy_q[2], vx_q[2], vy_q[1], vx_q[1],
                         vy_q[0], vx_q[0]};
          out_kind_q <= kind;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

@@ rtl/core/ttm_checker.sv @@
// Port-level checker for the triangle block, bound to the top level.
// Depends on ttm_pkg and the assertion macros header.
`include "triangle_transform_measure_defines.svh"

module ttm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [ttm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [ttm_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);
  import ttm_pkg::*;

  logic in_xfer, out_stall, point_tri, zero_meas;

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign point_tri = m_axis_tvalid_o
                     && m_axis_tdata_o[31:0] == m_axis_tdata_o[95:64]
                     && m_axis_tdata_o[95:64] == m_axis_tdata_o[159:128]
                     && m_axis_tdata_o[63:32] == m_axis_tdata_o[127:96]
                     && m_axis_tdata_o[127:96] == m_axis_tdata_o[191:160];
  assign zero_meas = m_axis_tuser_o == KIND_EQUI
                     && m_axis_tdata_o[273:192] == '0;

  // busy right after an input transfer, no instant result
  `TTM_ASSERT_NXT(a_busy_after_in, in_xfer, !s_axis_tready_o && !$rose(m_axis_tvalid_o), "ready or result right after input transfer")
  // a new result is posted as the sequencer returns to idle
  `TTM_ASSERT_IMP(a_result_idle, $rose(m_axis_tvalid_o), s_axis_tready_o, "result posted while busy")
  // a triangle collapsed to one point measures zero and is equilateral
  `TTM_ASSERT_IMP(a_point_tri, point_tri, zero_meas, "degenerate point not measured as zero")
  // stalled result holds
  `TTM_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind triangle_transform_measure ttm_checker u_ttm_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for triangle_transform_measure.
// Depends on ttm_pkg and the block's RTL; needs no other files.
`timescale 1ns / 100ps

module tb_top;
  import ttm_pkg::*;

  typedef struct packed {
    logic [2:0]  act;
    logic [1:0]  vtx;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [25:0] ang;
    logic [31:0] zf;
  } step_t;

  typedef struct packed {
    logic [5:0][31:0] crd;
    logic [33:0]      per;
    logic [47:0]      area;
    logic [1:0]       kind;
  } meas_t;

  localparam int LIMIT_CYCLES = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  step_t pending_steps[$];
  meas_t expected_meas[$];
  bit failed = 1'b0;
  int cycles = 0;
  int results_seen = 0;

  // Shadow of the block's state
  logic signed [31:0] sh_x[3];
  logic signed [31:0] sh_y[3];
  logic [31:0] sh_tol = 32'd4;

  triangle_transform_measure dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------- prediction ----------------
  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] zoom_coord(input logic signed [31:0] c,
                                                    input logic signed [31:0] f);
    logic [63:0] prod;
    logic [63:0] lim;
    bit neg;
    neg = (c < 0) != (f < 0);
    prod = abs64(c) * abs64(f);
    prod = (prod + 64'd32768) >> 16;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (prod > lim) prod = lim;
    return neg ? -prod[31:0] : prod[31:0];
  endfunction

  function automatic logic signed [63:0] gain_guard(input logic signed [63:0] v);
    logic [127:0] p;
    logic [63:0] r;
    p = {64'd0, abs64(v)} * {95'd0, GAIN_Q32};
    p = (p + (128'd1 << 23)) >> 24;
    r = p[63:0];
    return v < 0 ? -r : r;
  endfunction

  function automatic logic signed [63:0] atan_deg(input int i);
    case (i)
      0: return 64'sd754974720;   1: return 64'sd445687602;
      2: return 64'sd235489088;   3: return 64'sd119537938;
      4: return 64'sd60000934;    5: return 64'sd30029717;
      6: return 64'sd15018523;    7: return 64'sd7509720;
      8: return 64'sd3754917;     9: return 64'sd1877466;
      10: return 64'sd938734;     11: return 64'sd469367;
      default: return (64'sd961263669 + (64'sd1 << (i - 1))) >>> i;
    endcase
  endfunction

  task automatic rotate_shadow(input logic signed [25:0] ang);
    logic signed [63:0] z0, x, y, z, xs, ys;
    bit flip;
    z0 = ang;
    z0 = z0 * 256;
    flip = 1'b0;
    repeat (2) begin
      if (z0 > 64'sd3019898880) z0 = z0 - 64'sd6039797760;
      else if (z0 < -64'sd3019898880) z0 = z0 + 64'sd6039797760;
    end
    if (z0 > 64'sd1509949440) begin
      flip = 1'b1;
      z0 = z0 - 64'sd3019898880;
    end else if (z0 < -64'sd1509949440) begin
      flip = 1'b1;
      z0 = z0 + 64'sd3019898880;
    end
    for (int k = 0; k < 3; k++) begin
      x = sh_x[k];
      y = sh_y[k];
      z = z0;
      if (flip) begin
        x = -x;
        y = -y;
      end
      x = gain_guard(x);
      y = gain_guard(y);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - atan_deg(i);
        end else begin
          x = x + ys; y = y - xs; z = z + atan_deg(i);
        end
      end
      sh_x[k] = clamp32((x + 64'sd128) >>> 8);
      sh_y[k] = clamp32((y + 64'sd128) >>> 8);
    end
  endtask

  function automatic logic [127:0] side_sq(input int i, input int j);
    logic signed [63:0] dx, dy;
    logic [127:0] ax, ay;
    dx = sh_x[i];
    dx = dx - sh_x[j];
    dy = sh_y[i];
    dy = dy - sh_y[j];
    ax = abs64(dx);
    ay = abs64(dy);
    return ax * ax + ay * ay;
  endfunction

  function automatic logic [63:0] root_nearest(input logic [127:0] n);
    logic [63:0] r, c;
    logic [127:0] rem;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    rem = n - {64'd0, r} * {64'd0, r};
    if (rem > {64'd0, r}) r = r + 1;
    return r;
  endfunction

  function automatic bit near_eq(input logic [127:0] p, input logic [127:0] q);
    logic [127:0] d;
    d = (p >= q) ? p - q : q - p;
    return d <= {96'd0, sh_tol};
  endfunction

  task automatic predict_step(input step_t st);
    meas_t e;
    logic signed [65:0] t;
    logic [127:0] sa, sb, sc;
    logic [63:0] per;
    logic signed [127:0] d1x, d1y, d2x, d2y, cr;
    logic [127:0] ar;
    case (action_e'(st.act))
      ACT_LOAD: begin
        if (st.vtx < 2'd3) begin
          sh_x[st.vtx] = st.vx;
          sh_y[st.vtx] = st.vy;
        end
      end
      ACT_TRANSLATE: begin
        for (int k = 0; k < 3; k++) begin
          t = sh_x[k]; t = t + $signed(st.vx); sh_x[k] = clamp32(t);
          t = sh_y[k]; t = t + $signed(st.vy); sh_y[k] = clamp32(t);
        end
      end
      ACT_ROTATE: rotate_shadow(st.ang);
      ACT_ZOOM: begin
        for (int k = 0; k < 3; k++) begin
          sh_x[k] = zoom_coord(sh_x[k], st.zf);
          sh_y[k] = zoom_coord(sh_y[k], st.zf);
        end
      end
      default: ;  // query and unknown actions leave the vertices alone
    endcase
    sa = side_sq(0, 1);
    sb = side_sq(1, 2);
    sc = side_sq(2, 0);
    per = root_nearest(sa) + root_nearest(sb) + root_nearest(sc);
    if (per > 64'h3_ffff_ffff) per = 64'h3_ffff_ffff;
    d1x = sh_x[1]; d1x = d1x - sh_x[0];
    d1y = sh_y[1]; d1y = d1y - sh_y[0];
    d2x = sh_x[2]; d2x = d2x - sh_x[0];
    d2y = sh_y[2]; d2y = d2y - sh_y[0];
    cr = d1x * d2y - d1y * d2x;
    ar = cr < 0 ? -cr : cr;
    ar = (ar + 128'd65536) >> 17;
    if (ar > 128'hffff_ffff_ffff) ar = 128'hffff_ffff_ffff;
    if (near_eq(sa, sb) && near_eq(sb, sc)) e.kind = KIND_EQUI;
    else if (near_eq(sa + sb, sc) || near_eq(sb + sc, sa) || near_eq(sc + sa, sb))
      e.kind = KIND_RIGHT;
    else if (near_eq(sa, sb) || near_eq(sb, sc) || near_eq(sc, sa)) e.kind = KIND_ISO;
    else e.kind = KIND_SCALENE;
    for (int k = 0; k < 3; k++) begin
      e.crd[2 * k] = sh_x[k];
      e.crd[2 * k + 1] = sh_y[k];
    end
    e.per = per[33:0];
    e.area = ar[47:0];
    expected_meas.push_back(e);
  endtask

  // ---------------- sender: bursts and gaps ----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    step_t nx;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        predict_step(pending_steps.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          nx = pending_steps[0];
          s_tdata <= {6'd0, nx.zf, nx.ang, nx.vy, nx.vx};
          s_tuser <= {nx.vtx, nx.act};
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver: stall pattern and checking ----------------
  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    meas_t e, got;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.crd = m_tdata[191:0];
        got.per = m_tdata[225:192];
        got.area = m_tdata[273:226];
        got.kind = m_tuser;
        results_seen <= results_seen + 1;
        if (expected_meas.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          failed = 1'b1;
        end else begin
          e = expected_meas.pop_front();
          for (int k = 0; k < 6; k++)
            if (got.crd[k] !== e.crd[k]) begin
              $display("%0t: coord %0d expected %h actual %h", $time, k, e.crd[k],
                       got.crd[k]);
              failed = 1'b1;
            end
          if (got.per !== e.per) begin
            $display("%0t: perimeter expected %h actual %h", $time, e.per, got.per);
            failed = 1'b1;
          end
          if (got.area !== e.area) begin
            $display("%0t: area expected %h actual %h", $time, e.area, got.area);
            failed = 1'b1;
          end
          if (got.kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, got.kind);
            failed = 1'b1;
          end
        end
      end
      // one long hold-off while the sender keeps offering
      if (!hold_done && results_seen == 60) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode <= $urandom_range(0, 2);
          mode_left <= $urandom_range(20, 400);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (ready_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------- timeout ----------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic step_t mk(input action_e a, input logic [1:0] v,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [25:0] g, input logic [31:0] f);
    step_t s;
    s.act = a; s.vtx = v; s.vx = x; s.vy = y; s.ang = g; s.zf = f;
    return s;
  endfunction

  function automatic logic [31:0] coord_rand();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 400) - 200;  // tiny values
      default: return $signed($urandom_range(0, 13107200)) - 32'sd6553600;
    endcase
  endfunction

  function automatic step_t rand_step();
    step_t s;
    s.vx = coord_rand();
    s.vy = coord_rand();
    s.ang = 26'($urandom_range(0, 47185920) - 23592960);
    s.zf = ($urandom_range(0, 4) == 0) ? $urandom
           : $signed($urandom_range(0, 524288)) - 32'sd262144;
    s.vtx = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 19))
      0: s.act = 3'($urandom_range(5, 7));
      1: begin s.act = ACT_LOAD; s.vtx = 2'd3; end
      2, 3, 4: s.act = ACT_TRANSLATE;
      5, 6, 7: s.act = ACT_ROTATE;
      8, 9, 10: s.act = ACT_ZOOM;
      11: s.act = ACT_QUERY;
      default: s.act = ACT_LOAD;
    endcase
    if (s.act == ACT_TRANSLATE && $urandom_range(0, 3) != 0) begin
      s.vx = $signed($urandom_range(0, 1310720)) - 32'sd655360;
      s.vy = $signed($urandom_range(0, 1310720)) - 32'sd655360;
    end
    return s;
  endfunction

  // often a fresh triangle, then a few random steps on it
  task automatic add_random(input int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 3) != 0) begin
        for (int v = 0; v < 3; v++) begin
          pending_steps.push_back(mk(ACT_LOAD, 2'(v), coord_rand(), coord_rand(), 0, 0));
          k++;
        end
      end
      repeat ($urandom_range(1, 5)) begin
        pending_steps.push_back(rand_step());
        k++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_steps.size() != 0 || expected_meas.size() != 0 || s_tvalid)
      @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sh_tol = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    for (int k = 0; k < 3; k++) begin
      sh_x[k] = '0;
      sh_y[k] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: degenerate reset triangle, right, isosceles, extremes
    pending_steps.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 1, 3 * ONE, 0, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 2, 0, 4 * ONE, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 3, 32'h7fffffff, 32'h7fffffff, 0, 0));
    pending_steps.push_back(mk(ACT_ROTATE, 0, 0, 0, 26'(90 * 65536), 0));
    pending_steps.push_back(mk(ACT_ROTATE, 0, 0, 0, 26'(180 * 65536), 0));
    pending_steps.push_back(mk(ACT_ROTATE, 0, 0, 0, -26'(180 * 65536), 0));
    pending_steps.push_back(mk(ACT_ROTATE, 0, 0, 0, 26'(23592960), 0));
    pending_steps.push_back(mk(ACT_ROTATE, 0, 0, 0, -26'(23592960), 0));
    pending_steps.push_back(mk(ACT_ROTATE, 0, 0, 0, 26'(95 * 65536), 0));
    pending_steps.push_back(mk(ACT_LOAD, 2, 6 * ONE, 0, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 1, 3 * ONE, 5 * ONE, 0, 0));
    pending_steps.push_back(mk(ACT_ZOOM, 0, 0, 0, 0, 2 * ONE));
    pending_steps.push_back(mk(ACT_ZOOM, 0, 0, 0, 0, -ONE));
    pending_steps.push_back(mk(ACT_ZOOM, 0, 0, 0, 0, 32'h7fffffff));
    pending_steps.push_back(mk(ACT_ZOOM, 0, 0, 0, 0, 32'h80000000));
    pending_steps.push_back(mk(ACT_TRANSLATE, 0, 32'h7fffffff, 32'h80000000, 0, 0));
    pending_steps.push_back(mk(ACT_TRANSLATE, 0, 32'h80000000, 32'h7fffffff, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 0, 32'h80000000, 32'h80000000, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 1, 32'h7fffffff, 32'h80000000, 0, 0));
    pending_steps.push_back(mk(ACT_LOAD, 2, 32'h80000000, 32'h7fffffff, 0, 0));
    pending_steps.push_back(mk(action_e'(3'd5), 0, 0, 0, 0, 0));
    pending_steps.push_back(mk(action_e'(3'd7), 3, 32'hffffffff, 32'hffffffff,
                               26'h3ffffff, 32'hffffffff));
    pending_steps.push_back(mk(ACT_ZOOM, 0, 0, 0, 0, 0));
    wait_idle();

    // random phases across tolerance settings, extremes included
    write_tolerance(32'd0);
    add_random(200);
    wait_idle();
    write_tolerance(32'hffffffff);
    add_random(100);
    wait_idle();
    write_tolerance($urandom);
    add_random(150);
    wait_idle();
    write_tolerance(32'd4);
    add_random(150);
    wait_idle();

    repeat (300) @(posedge clk_i);
    if (!failed && expected_meas.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (expected_meas.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_meas.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ttm_pkg.sv
rtl/core/ttm_mult.sv
rtl/core/ttm_sqrt.sv
rtl/core/triangle_transform_measure.sv
rtl/core/ttm_checker.sv
tb/tb_top.sv
